>>> src/assert_macros.svh
// assertion macros shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define AST_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> src/lom_pkg.sv
// ----------------------------------------------------------------------------
// lom_pkg
// shared constants and controller/datapath types of the order matcher
// ----------------------------------------------------------------------------
package lom_pkg;

  localparam int BOOK_DEPTH = 32;
  localparam int IDX_W      = $clog2(BOOK_DEPTH);
  localparam int CNT_W      = $clog2(BOOK_DEPTH + 1);

  localparam logic [1:0] KIND_TRADE   = 2'd0;
  localparam logic [1:0] KIND_RESTED  = 2'd1;
  localparam logic [1:0] KIND_FILLED  = 2'd2;
  localparam logic [1:0] KIND_DROPPED = 2'd3;

  // controller commands
  typedef struct packed {
    logic load;
    logic scan_init;
    logic scan_step;
    logic trade;
    logic finish;
  } cmd_t;

  // datapath status
  typedef struct packed {
    logic go_match;
    logic scan_end;
    logic crosses;
  } sts_t;

  // write controls of one book side
  typedef struct packed {
    logic             upd;
    logic             remove;
    logic             append;
    logic [IDX_W-1:0] idx;
    logic [31:0]      qty;
    logic [31:0]      app_price;
    logic [31:0]      app_qty;
    logic [31:0]      app_num;
  } book_wr_t;

endpackage

>>> src/limit_order_matcher.sv
// ----------------------------------------------------------------------------
// limit_order_matcher
// price-time priority limit order book with one bid and one ask side
// ----------------------------------------------------------------------------
// usage:
//   an order (side_i, limit_price_i, order_qty_i) transfers in at a clock edge
//   with start high and busy low; it gets the next order number, from 1
//   results leave on the result ports for exactly one cycle each, marked by
//   result_valid_o: zero or more trades, then one final result with last_o
//   the receiver cannot stall, so results are never held back
// timing:
//   each trade takes a check state, a scan of the opposite side at one
//   resting order per cycle and a trade state; the final result follows
//   the final state, and busy drops as it appears
//   the worst case is an order that sweeps a full side, as the book
//   registers are scanned one after another
// reset:
//   both sides empty, order numbering restarts at 1, no result pending
// ----------------------------------------------------------------------------
module limit_order_matcher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        side_i,
  input  logic [31:0] limit_price_i,
  input  logic [31:0] order_qty_i,
  output logic        result_valid_o,
  output logic [1:0]  kind_o,
  output logic [31:0] order_number_o,
  output logic [31:0] buyer_number_o,
  output logic [31:0] seller_number_o,
  output logic [31:0] fill_price_o,
  output logic [31:0] fill_qty_o,
  output logic        last_o
);
  import lom_pkg::*;

  // command and status between controller and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: scan, trade, finish
  lom_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .busy, .sts_i(sts), .cmd_o(cmd)
  );

  // books, order registers and the result register
  lom_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .side_i, .limit_price_i, .order_qty_i,
    .result_valid_o, .kind_o, .order_number_o, .buyer_number_o,
    .seller_number_o, .fill_price_o, .fill_qty_o, .last_o
  );

endmodule

>>> src/lom_book.sv
// ----------------------------------------------------------------------------
// lom_book
// one side of the book: resting orders in arrival order, with update, remove
// with shift-up, and append
// ----------------------------------------------------------------------------
module lom_book (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lom_pkg::book_wr_t       wr_i,
  input  logic [lom_pkg::IDX_W-1:0] rd_idx_i,
  output logic [31:0]             rd_price_o,
  output logic [31:0]             rd_qty_o,
  output logic [31:0]             rd_num_o,
  output logic [lom_pkg::CNT_W-1:0] count_o
);
  import lom_pkg::*;

  logic [31:0] price_q [BOOK_DEPTH];
  logic [31:0] qty_q   [BOOK_DEPTH];
  logic [31:0] num_q   [BOOK_DEPTH];
  logic [CNT_W-1:0] count_q;
  logic [IDX_W-1:0] app_idx;

  assign app_idx    = count_q[IDX_W-1:0];
  assign rd_price_o = price_q[rd_idx_i];
  assign rd_qty_o   = qty_q[rd_idx_i];
  assign rd_num_o   = num_q[rd_idx_i];
  assign count_o    = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (wr_i.remove) begin
      count_q <= count_q - CNT_W'(1);
    end else if (wr_i.append) begin
      count_q <= count_q + CNT_W'(1);
    end
  end

  for (genvar i = 0; i < BOOK_DEPTH; i++) begin : g_entry
    localparam int SRC = (i < BOOK_DEPTH - 1) ? i + 1 : i;
    always_ff @(posedge clk_i) begin
      if (wr_i.remove && (IDX_W'(i) >= wr_i.idx)) begin
        price_q[i] <= price_q[SRC];
        qty_q[i]   <= qty_q[SRC];
        num_q[i]   <= num_q[SRC];
      end else if (wr_i.upd && (IDX_W'(i) == wr_i.idx)) begin
        qty_q[i] <= wr_i.qty;
      end else if (wr_i.append && (IDX_W'(i) == app_idx)) begin
        price_q[i] <= wr_i.app_price;
        qty_q[i]   <= wr_i.app_qty;
        num_q[i]   <= wr_i.app_num;
      end
    end
  end

endmodule

>>> src/lom_dp.sv
// ----------------------------------------------------------------------------
// lom_dp
// datapath: order registers, best-entry scan, trade arithmetic, result register
// ----------------------------------------------------------------------------
module lom_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lom_pkg::cmd_t             cmd_i,
  output lom_pkg::sts_t             sts_o,
  input  logic                      side_i,
  input  logic [31:0]               limit_price_i,
  input  logic [31:0]               order_qty_i,
  output logic                      result_valid_o,
  output logic [1:0]                kind_o,
  output logic [31:0]               order_number_o,
  output logic [31:0]               buyer_number_o,
  output logic [31:0]               seller_number_o,
  output logic [31:0]               fill_price_o,
  output logic [31:0]               fill_qty_o,
  output logic                      last_o
);
  import lom_pkg::*;

  logic             side_q;
  logic [31:0]      limit_q, remain_q, num_q, next_num_q;
  logic [CNT_W-1:0] idx_q;
  logic [IDX_W-1:0] best_idx_q;
  logic [31:0]      best_price_q, best_qty_q, best_num_q;

  logic [IDX_W-1:0] rd_idx;
  logic [31:0]      bid_p, bid_q, bid_n, ask_p, ask_q, ask_n;
  logic [31:0]      rd_p, rd_q, rd_n;
  logic [CNT_W-1:0] bid_cnt, ask_cnt, opp_cnt, own_cnt;
  logic             better, can_rest, used_up;
  logic [31:0]      trade_qty, left_qty;
  book_wr_t         bid_wr, ask_wr, opp_wr, own_wr;

  logic             valid_q, last_q;
  logic [1:0]       kind_q;
  logic [31:0]      onum_q, buyer_q, seller_q, price_q, qty_q;

  assign rd_idx  = cmd_i.scan_init ? '0 : idx_q[IDX_W-1:0];
  assign opp_cnt = side_q ? bid_cnt : ask_cnt;
  assign own_cnt = side_q ? ask_cnt : bid_cnt;
  assign rd_p    = side_q ? bid_p : ask_p;
  assign rd_q    = side_q ? bid_q : ask_q;
  assign rd_n    = side_q ? bid_n : ask_n;

  // sell wants the highest bid, buy the lowest ask; ties keep the earlier one
  assign better    = side_q ? (rd_p > best_price_q) : (rd_p < best_price_q);
  assign trade_qty = (remain_q < best_qty_q) ? remain_q : best_qty_q;
  assign left_qty  = best_qty_q - trade_qty;
  assign used_up   = (left_qty == '0);
  assign can_rest  = (own_cnt < CNT_W'(BOOK_DEPTH));

  assign sts_o.go_match = (remain_q != '0) && (opp_cnt != '0);
  assign sts_o.scan_end = (idx_q >= opp_cnt);
  assign sts_o.crosses  = side_q ? (best_price_q >= limit_q) : (best_price_q <= limit_q);

  always_comb begin
    opp_wr           = '0;
    opp_wr.idx       = best_idx_q;
    opp_wr.qty       = left_qty;
    opp_wr.upd       = cmd_i.trade && !used_up;
    opp_wr.remove    = cmd_i.trade && used_up;
    own_wr           = '0;
    own_wr.append    = cmd_i.finish && (remain_q != '0) && can_rest;
    own_wr.app_price = limit_q;
    own_wr.app_qty   = remain_q;
    own_wr.app_num   = num_q;
    bid_wr           = side_q ? opp_wr : own_wr;
    ask_wr           = side_q ? own_wr : opp_wr;
  end

  lom_book u_bid (
    .clk_i, .rst_ni, .wr_i(bid_wr), .rd_idx_i(rd_idx),
    .rd_price_o(bid_p), .rd_qty_o(bid_q), .rd_num_o(bid_n), .count_o(bid_cnt)
  );

  lom_book u_ask (
    .clk_i, .rst_ni, .wr_i(ask_wr), .rd_idx_i(rd_idx),
    .rd_price_o(ask_p), .rd_qty_o(ask_q), .rd_num_o(ask_n), .count_o(ask_cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_num_q <= 32'd1;
      valid_q    <= 1'b0;
    end else begin
      valid_q <= cmd_i.trade || cmd_i.finish;
      if (cmd_i.load) begin
        next_num_q <= next_num_q + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      side_q   <= side_i;
      limit_q  <= limit_price_i;
      remain_q <= order_qty_i;
      num_q    <= next_num_q;
    end
    if (cmd_i.scan_init) begin
      idx_q        <= CNT_W'(1);
      best_idx_q   <= '0;
      best_price_q <= rd_p;
      best_qty_q   <= rd_q;
      best_num_q   <= rd_n;
    end else if (cmd_i.scan_step) begin
      idx_q <= idx_q + CNT_W'(1);
      if (better) begin
        best_idx_q   <= idx_q[IDX_W-1:0];
        best_price_q <= rd_p;
        best_qty_q   <= rd_q;
        best_num_q   <= rd_n;
      end
    end
    if (cmd_i.trade) begin
      remain_q <= remain_q - trade_qty;
      kind_q   <= KIND_TRADE;
      onum_q   <= num_q;
      buyer_q  <= side_q ? best_num_q : num_q;
      seller_q <= side_q ? num_q : best_num_q;
      price_q  <= best_price_q;
      qty_q    <= trade_qty;
      last_q   <= 1'b0;
    end else if (cmd_i.finish) begin
      kind_q   <= (remain_q == '0) ? KIND_FILLED : (can_rest ? KIND_RESTED : KIND_DROPPED);
      onum_q   <= num_q;
      buyer_q  <= '0;
      seller_q <= '0;
      price_q  <= '0;
      qty_q    <= remain_q;
      last_q   <= 1'b1;
    end
  end

  assign result_valid_o  = valid_q;
  assign kind_o          = kind_q;
  assign order_number_o  = onum_q;
  assign buyer_number_o  = buyer_q;
  assign seller_number_o = seller_q;
  assign fill_price_o    = price_q;
  assign fill_qty_o      = qty_q;
  assign last_o          = last_q;

endmodule

>>> src/lom_ctrl.sv
// ----------------------------------------------------------------------------
// lom_ctrl
// controller: load, scan for the best resting order, trade, finish
// ----------------------------------------------------------------------------
module lom_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  lom_pkg::sts_t sts_i,
  output lom_pkg::cmd_t cmd_o
);
  import lom_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_TRADE = 3'd3;
  localparam logic [2:0] S_FINAL = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.go_match) begin
          cmd_o.scan_init = 1'b1;
          state_d         = S_SCAN;
        end else begin
          state_d = S_FINAL;
        end
      end
      S_SCAN: begin
        if (!sts_i.scan_end) begin
          cmd_o.scan_step = 1'b1;
        end else if (sts_i.crosses) begin
          state_d = S_TRADE;
        end else begin
          state_d = S_FINAL;
        end
      end
      S_TRADE: begin
        cmd_o.trade = 1'b1;
        state_d     = S_CHECK;
      end
      S_FINAL: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

>>> src/lom_checker.sv
// ----------------------------------------------------------------------------
// lom_port_checker
// port-level checks of the order matcher result sequence
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lom_port_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       result_valid_i,
  input logic [1:0] kind_i,
  input logic       last_i
);
  import lom_pkg::*;

  `AST_NXT(a_start_busy, clk_i, rst_ni, start && !busy, busy)
  `AST_IMP(a_trade_not_last, clk_i, rst_ni, result_valid_i && kind_i == KIND_TRADE, !last_i)
  `AST_IMP(a_last_not_trade, clk_i, rst_ni, result_valid_i && last_i, kind_i != KIND_TRADE)
  `AST_IMP(a_trade_busy, clk_i, rst_ni, result_valid_i && !last_i, busy)
  `AST_IMP(a_last_idle, clk_i, rst_ni, result_valid_i && last_i, !busy)

endmodule

bind limit_order_matcher lom_port_checker u_lom_port_checker (
  .clk_i, .rst_ni, .start, .busy, .result_valid_i(result_valid_o),
  .kind_i(kind_o), .last_i(last_o)
);
